// ----- src/krt_pkg.sv -----
`timescale 1ns / 1ps
// Package for the keyed record table: constants, operation and status codes,
// the request and result words, and the controller/datapath command and status.
// Depends on nothing.
package krt_pkg;

  localparam int TABLE_ENTRIES_DEF = 32;
  localparam int KEY_BYTES_DEF     = 32;
  localparam int STR_LEN           = 30;
  localparam int MAX_RESULTS       = 32;
  localparam int WORD_BITS         = 64;
  localparam int RAW_KEY_BITS      = 4 * WORD_BITS;
  localparam int VALUE_BITS        = 16 + WORD_BITS;
  localparam int MATCH_W           = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CITY   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_CLEARED   = 3'd5
  } status_t;

  typedef struct packed {
    op_t         op;
    logic [63:0] name_word0;
    logic [63:0] name_word1;
    logic [63:0] name_word2;
    logic [63:0] name_word3;
    logic [15:0] value_high;
    logic [63:0] value_low;
    logic [63:0] city_word0;
    logic [63:0] city_word1;
    logic [63:0] city_word2;
    logic [63:0] city_word3;
  } request_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] out_value_high;
    logic [63:0] out_value_low;
    logic [63:0] out_name_word0;
    logic [63:0] out_name_word1;
    logic [63:0] out_name_word2;
    logic [63:0] out_name_word3;
    logic        last;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    issue;
    logic    take_hit;
    logic    write;
    logic    clear;
    logic    emit;
    logic    last;
    logic    with_value;
    logic    with_name;
    status_t code;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic more;
    logic rvalid;
    logic hit;
    logic found;
    logic pend_valid;
    logic match_full;
    logic table_full;
  } stat_t;

endpackage

// ----- src/krt_ram.sv -----
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module krt_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/krt_ctrl.sv -----
`timescale 1ns / 1ps
// Controller of the keyed record table: sequences load, scan and finish.
// Depends on krt_pkg for the command and status structs and the codes.
module krt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  krt_pkg::stat_t stat,
  output logic          busy,
  output krt_pkg::cmd_t cmd
);
  import krt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.code   = ST_INSERTED;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.op == OP_CLEAR) begin
          state_next = S_FINISH;
        end else begin
          cmd.issue = stat.more;
          if (stat.hit) begin
            cmd.take_hit = 1'b1;
            if (stat.op == OP_CITY) begin
              // A new match pushes the one held back out; it is not the last.
              if (stat.pend_valid) begin
                cmd.emit      = 1'b1;
                cmd.with_name = 1'b1;
                cmd.code      = ST_FOUND;
              end
              if (stat.match_full) begin
                state_next = S_FINISH;
              end
            end else begin
              state_next = S_FINISH;
            end
          end else if (!stat.more && !stat.rvalid) begin
            state_next = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        cmd.emit   = 1'b1;
        cmd.last   = 1'b1;
        state_next = S_IDLE;
        case (stat.op)
          OP_INSERT: begin
            if (stat.found) begin
              cmd.code = ST_DUPLICATE;
            end else if (stat.table_full) begin
              cmd.code = ST_FULL;
            end else begin
              cmd.code  = ST_INSERTED;
              cmd.write = 1'b1;
            end
          end
          OP_LOOKUP: begin
            if (stat.found) begin
              cmd.code       = ST_FOUND;
              cmd.with_value = 1'b1;
            end else begin
              cmd.code = ST_NOT_FOUND;
            end
          end
          OP_CITY: begin
            if (stat.pend_valid) begin
              cmd.code      = ST_FOUND;
              cmd.with_name = 1'b1;
            end else begin
              cmd.code = ST_NOT_FOUND;
            end
          end
          default: begin
            cmd.code  = ST_CLEARED;
            cmd.clear = 1'b1;
          end
        endcase
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/krt_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the keyed record table: request registers, record RAM, scan
// index, key compare, held-back match and the result register.
// Depends on krt_pkg and krt_ram.
module krt_datapath #(
  parameter int TABLE_ENTRIES = 32,
  parameter int KEY_BYTES     = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  krt_pkg::request_t request,
  input  krt_pkg::cmd_t     cmd,
  output krt_pkg::stat_t    stat,
  output logic              result_valid,
  output krt_pkg::result_t  result
);
  import krt_pkg::*;

  localparam int KEY_LIMIT = (KEY_BYTES < STR_LEN - 1) ? KEY_BYTES : STR_LEN - 1;
  localparam int KEY_BITS  = KEY_LIMIT * 8;
  localparam int REC_BITS  = 2 * KEY_BITS + VALUE_BITS;
  localparam int IDX_W     = $clog2(TABLE_ENTRIES + 1);
  localparam int ADDR_W    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // A key ends at its first zero byte or at the length limit; the rest is zero.
  function automatic logic [KEY_BITS-1:0] norm_key(input logic [RAW_KEY_BITS-1:0] raw);
    logic [KEY_BITS-1:0] res;
    logic                keep;
    res  = '0;
    keep = 1'b1;
    for (int b = 0; b < KEY_LIMIT; b++) begin
      keep = keep && (raw[8*b +: 8] != 8'h00);
      if (keep) begin
        res[8*b +: 8] = raw[8*b +: 8];
      end
    end
    return res;
  endfunction

  op_t                 req_op;
  logic [KEY_BITS-1:0] req_name;
  logic [KEY_BITS-1:0] req_city;
  logic [VALUE_BITS-1:0] req_value;
  logic [IDX_W-1:0]    idx;
  logic [IDX_W-1:0]    idx_dec;
  logic [IDX_W-1:0]    count;
  logic                rvalid;
  logic                found;
  logic                pend_valid;
  logic [KEY_BITS-1:0] pend_name;
  logic [VALUE_BITS-1:0] value_hold;
  logic [MATCH_W-1:0]  match_cnt;
  logic                table_full;
  logic                hit;

  logic [REC_BITS-1:0]   wdata;
  logic [REC_BITS-1:0]   rdata;
  logic [KEY_BITS-1:0]   rd_name;
  logic [KEY_BITS-1:0]   rd_city;
  logic [VALUE_BITS-1:0] rd_value;
  logic [RAW_KEY_BITS-1:0] raw_name;
  logic [RAW_KEY_BITS-1:0] raw_city;
  logic [RAW_KEY_BITS-1:0] name_ext;
  result_t               result_next;

  assign raw_name = {request.name_word3, request.name_word2,
                     request.name_word1, request.name_word0};
  assign raw_city = {request.city_word3, request.city_word2,
                     request.city_word1, request.city_word0};

  assign idx_dec    = idx - IDX_W'(1);
  assign table_full = (count == IDX_W'(TABLE_ENTRIES));
  assign wdata      = {req_name, req_city, req_value};
  assign rd_name    = rdata[REC_BITS-1 -: KEY_BITS];
  assign rd_city    = rdata[VALUE_BITS +: KEY_BITS];
  assign rd_value   = rdata[VALUE_BITS-1:0];

  assign hit = rvalid && ((req_op == OP_CITY) ? (rd_city == req_city)
                                              : (rd_name == req_name));

  krt_ram #(
    .WIDTH (REC_BITS),
    .DEPTH (TABLE_ENTRIES),
    .ADDR_W(ADDR_W)
  ) u_records (
    .clk  (clk),
    .we   (cmd.write),
    .waddr(count[ADDR_W-1:0]),
    .wdata(wdata),
    .raddr(idx_dec[ADDR_W-1:0]),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op    <= request.op;
      req_name  <= norm_key(raw_name);
      req_city  <= norm_key(raw_city);
      req_value <= {request.value_high, request.value_low};
    end
    if (cmd.take_hit) begin
      pend_name  <= rd_name;
      value_hold <= rd_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      idx        <= '0;
      rvalid     <= 1'b0;
      found      <= 1'b0;
      pend_valid <= 1'b0;
      match_cnt  <= '0;
    end else begin
      rvalid <= cmd.issue;
      if (cmd.load) begin
        idx        <= count;
        found      <= 1'b0;
        pend_valid <= 1'b0;
        match_cnt  <= '0;
      end else begin
        if (cmd.issue) begin
          idx <= idx_dec;
        end
        if (cmd.take_hit) begin
          found      <= 1'b1;
          pend_valid <= 1'b1;
          match_cnt  <= match_cnt + MATCH_W'(1);
        end
      end
      if (cmd.clear) begin
        count <= '0;
      end else if (cmd.write) begin
        count <= count + IDX_W'(1);
      end
    end
  end

  assign stat.op         = req_op;
  assign stat.more       = (idx != '0);
  assign stat.rvalid     = rvalid;
  assign stat.hit        = hit;
  assign stat.found      = found;
  assign stat.pend_valid = pend_valid;
  assign stat.match_full = (match_cnt == MATCH_W'(MAX_RESULTS - 1));
  assign stat.table_full = table_full;

  assign name_ext = cmd.with_name ? RAW_KEY_BITS'(pend_name) : '0;

  always_comb begin
    result_next                = '0;
    result_next.status         = cmd.code;
    result_next.last           = cmd.last;
    result_next.out_value_high = cmd.with_value ? value_hold[VALUE_BITS-1 -: 16] : 16'h0;
    result_next.out_value_low  = cmd.with_value ? value_hold[WORD_BITS-1:0] : '0;
    result_next.out_name_word0 = name_ext[0*WORD_BITS +: WORD_BITS];
    result_next.out_name_word1 = name_ext[1*WORD_BITS +: WORD_BITS];
    result_next.out_name_word2 = name_ext[2*WORD_BITS +: WORD_BITS];
    result_next.out_name_word3 = name_ext[3*WORD_BITS +: WORD_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      result <= result_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= IDX_W'(TABLE_ENTRIES))
    else $error("record count beyond table size");

  a_write_room: assert property (@(posedge clk) disable iff (rst)
    cmd.write |-> !table_full && !found)
    else $error("record written into a full table or over a duplicate");

  a_write_count: assert property (@(posedge clk) disable iff (rst)
    cmd.write |=> count == $past(count) + IDX_W'(1))
    else $error("record count did not advance after a write");

  a_match_bound: assert property (@(posedge clk) disable iff (rst)
    match_cnt <= MATCH_W'(MAX_RESULTS))
    else $error("more city matches taken than may be reported");

  a_pend_found: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> found)
    else $error("held match without a recorded hit");
`endif

endmodule

// ----- src/keyed_record_table.sv -----
`timescale 1ns / 1ps
// Top level of the keyed record table: controller plus datapath.
// Depends on krt_pkg, krt_ctrl and krt_datapath.
//
//   channel   handshake              payload
//   request   start in, busy out     request (krt_pkg::request_t)
//   result    result_valid out       result  (krt_pkg::result_t)
//
// A request is taken when start is high and busy is low. Insert, lookup and
// city query scan the stored records newest first, one per cycle through the
// registered RAM read port; insert and lookup stop early when the name is
// found, and clear does no scan.
// City query words appear as matches are found, and the final word of every
// request comes in the first cycle with busy low, with last set on it.
// The receiver cannot hold result words off; the only stall is busy.
// Reset empties the table; the record RAM itself is not cleared.
module keyed_record_table #(
  parameter int TABLE_ENTRIES = krt_pkg::TABLE_ENTRIES_DEF,
  parameter int KEY_BYTES     = krt_pkg::KEY_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  krt_pkg::request_t request,
  output logic              result_valid,
  output krt_pkg::result_t  result
);
  import krt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  krt_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .stat (stat),
    .busy (busy),
    .cmd  (cmd)
  );

  krt_datapath #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .KEY_BYTES    (KEY_BYTES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .request     (request),
    .cmd         (cmd),
    .stat        (stat),
    .result_valid(result_valid),
    .result      (result)
  );

endmodule
